[sv/reliable_window_sender_unit_macros.svh]
// assertion macros for the reliable window sender
// used by reliable_window_sender_unit only; expects clk_i and rst_ni in scope
`ifndef RELIABLE_WINDOW_SENDER_UNIT_MACROS_SVH
`define RELIABLE_WINDOW_SENDER_UNIT_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define RWS_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("rws invariant violated");

// condition that must hold in the cycle after a trigger
`define RWS_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error("rws sequencing check failed");

`endif

[sv/rws_pkg.sv]
// shared types and constants of the reliable window sender
// no dependencies
package rws_pkg;

  localparam int unsigned POS_W     = 11;  // cell position, enough for 1024 cells
  localparam int unsigned SEQ_W     = 31;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned RTT_W     = 24;  // unsigned Q16.8
  localparam int unsigned TO_W      = 16;
  localparam int unsigned CNT_OUT_W = 7;
  localparam int unsigned MAX_POPS  = 64;

  localparam logic [RTT_W-1:0] RTT_RESET         = 24'd76800;  // 300 ms
  localparam logic [RTT_W-1:0] DEV_RESET         = 24'd25600;  // 100 ms
  localparam logic [TO_W-1:0]  TIMEOUT_RESET     = 16'd1000;
  localparam logic [TO_W-1:0]  MAX_TIMEOUT_RESET = 16'd2000;
  localparam logic [7:0]       GAIN_DEV_OLD      = 8'd179;     // 0.7 in 1/256
  localparam logic [7:0]       GAIN_DEV_NEW      = 8'd77;      // 0.3 in 1/256

  // register map, decoded on paddr bit 2
  localparam logic REG_MAX_TIMEOUT = 1'b0;

  typedef enum logic [1:0] {
    OP_SEND  = 2'd0,
    OP_RECV  = 2'd1,
    OP_TIMER = 2'd2,
    OP_RSVD  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_TX_NEW   = 3'd0,
    KIND_REFUSED  = 3'd1,
    KIND_ACKED    = 3'd2,
    KIND_LOSS     = 3'd3,
    KIND_SEND_ACK = 3'd4,
    KIND_NONE     = 3'd5
  } kind_e;

  // broadcast to every window cell
  typedef struct packed {
    logic              pop;
    logic [TIME_W-1:0] now;
    logic              send_en;
    logic [POS_W-1:0]  send_pos;
    logic              loss_en;
    logic [POS_W-1:0]  loss_cnt;
    logic              tail_a_en;
    logic [POS_W-1:0]  tail_a_pos;
    logic              tail_b_en;
    logic [POS_W-1:0]  tail_b_pos;
  } cell_ctl_t;

  // requests to the rtt estimator
  typedef struct packed {
    logic              sample_en;
    logic [TIME_W-1:0] elapsed;
    logic              loss_en;
    logic [TO_W-1:0]   to_cap;
  } rtt_ctl_t;

endpackage

[sv/rws_cell.sv]
// one window cell: send stamp and resent flag of one outstanding packet
// depends on rws_pkg
module rws_cell (
  input  logic                      clk_i,
  input  rws_pkg::cell_ctl_t        ctl_i,
  input  logic [rws_pkg::POS_W-1:0] idx_i,
  input  logic [rws_pkg::TIME_W-1:0] nb_time_i,
  input  logic                      nb_retx_i,
  output logic [rws_pkg::TIME_W-1:0] time_o,
  output logic                      retx_o
);
  import rws_pkg::*;

  logic [TIME_W-1:0] time_q, time_d;
  logic              retx_q, retx_d;
  logic              mark;

  // shift toward the head on a pop, then apply writes at new positions
  always_comb begin
    time_d = ctl_i.pop ? nb_time_i : time_q;
    retx_d = ctl_i.pop ? nb_retx_i : retx_q;
    mark   = (ctl_i.loss_en && (idx_i < ctl_i.loss_cnt)) ||
             (ctl_i.tail_a_en && (idx_i == ctl_i.tail_a_pos)) ||
             (ctl_i.tail_b_en && (idx_i == ctl_i.tail_b_pos));
    if (ctl_i.send_en && (idx_i == ctl_i.send_pos)) begin
      time_d = ctl_i.now;
      retx_d = 1'b0;
    end
    if (mark) begin
      time_d = ctl_i.now;
      retx_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q <= time_d;
    retx_q <= retx_d;
  end

  assign time_o = time_q;
  assign retx_o = retx_q;

endmodule

[sv/rws_rtt.sv]
// smoothed rtt, deviation and retransmission timeout
// depends on rws_pkg
module rws_rtt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rws_pkg::rtt_ctl_t         ctl_i,
  output logic [rws_pkg::RTT_W-1:0] rtt_o,
  output logic [rws_pkg::TO_W-1:0]  timeout_o
);
  import rws_pkg::*;

  logic [RTT_W-1:0] rtt_q, rtt_d, dev_q, dev_d;
  logic [TO_W-1:0]  to_q, to_d;
  logic             recalc_q, recalc_d;

  logic [15:0]      samp;
  logic [RTT_W-1:0] big, diff;
  logic [33:0]      dsum;
  logic [26:0]      rsum;
  logic [26:0]      tsum;
  logic [16:0]      dbl;

  always_comb begin
    // sample saturated to 16 bits, then into Q16.8
    samp = (|ctl_i.elapsed[31:16]) ? 16'hFFFF : ctl_i.elapsed[15:0];
    big  = {samp, 8'h00};
    diff = (big > rtt_q) ? (big - rtt_q) : (rtt_q - big);
    dsum = 34'(dev_q) * 34'(GAIN_DEV_OLD) + 34'(diff) * 34'(GAIN_DEV_NEW) + 34'd128;
    rsum = 27'(rtt_q) + 27'({rtt_q, 1'b0}) + 27'(big) + 27'd2;
    tsum = 27'({rtt_q, 1'b0}) + 27'({dev_q, 2'b00});
    dbl  = {to_q, 1'b0};

    rtt_d    = rtt_q;
    dev_d    = dev_q;
    to_d     = to_q;
    recalc_d = 1'b0;
    if (ctl_i.sample_en) begin
      dev_d    = (|dsum[33:32]) ? {RTT_W{1'b1}} : dsum[31:8];
      rtt_d    = rsum[26] ? {RTT_W{1'b1}} : rsum[25:2];
      recalc_d = 1'b1;
    end
    // timeout follows the estimate in the next cycle
    if (recalc_q) begin
      to_d = (|tsum[26:24]) ? {TO_W{1'b1}} : tsum[23:8];
    end
    if (ctl_i.loss_en) begin
      to_d = (dbl > {1'b0, ctl_i.to_cap}) ? ctl_i.to_cap : dbl[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rtt_q    <= RTT_RESET;
      dev_q    <= DEV_RESET;
      to_q     <= TIMEOUT_RESET;
      recalc_q <= 1'b0;
    end else begin
      rtt_q    <= rtt_d;
      dev_q    <= dev_d;
      to_q     <= to_d;
      recalc_q <= recalc_d;
    end
  end

  assign rtt_o     = rtt_q;
  assign timeout_o = to_q;

endmodule

[sv/reliable_window_sender_unit.sv]
// Sender control of a reliable datagram link. Outstanding packets sit in a
// chain of WINDOW_DEPTH cells, head at cell 0; an ack shifts the chain by one
// cell per popped packet. An event is accepted in ST_IDLE and evaluated in
// ST_EVAL; a received ack that pops n packets (n up to 64) then passes, for
// each packet, through ST_POP_RTT for the rtt estimator and ST_POP_EMIT for
// the cell shift and window update. Output stalls hold ST_EVAL and ST_POP_EMIT.
// Each result word waits in an output register; the block takes the next
// event once the last word of the current one has been loaded there.
// depends on rws_pkg, rws_cell, rws_rtt and the macro header
module reliable_window_sender_unit #(
  parameter int unsigned WINDOW_DEPTH = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // event channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  operation_i,
  input  logic [31:0]                 now_ms_i,
  input  logic                        is_ack_i,
  input  logic signed [31:0]          ack_number_i,
  input  logic [30:0]                 rx_sequence_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  kind_o,
  output logic [30:0]                 sequence_res_o,
  output logic                        resend_a_valid_o,
  output logic [30:0]                 resend_a_seq_o,
  output logic                        resend_b_valid_o,
  output logic [30:0]                 resend_b_seq_o,
  output logic [6:0]                  retransmit_count_o,
  output logic signed [31:0]          ack_out_o,
  output logic [15:0]                 rtt_ms_o,
  output logic                        last_o
);
  import rws_pkg::*;

`include "reliable_window_sender_unit_macros.svh"

  localparam int unsigned CntW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned WlW  = $clog2(WINDOW_DEPTH + 2);

  typedef enum logic [3:0] {
    ST_IDLE     = 4'b0001,
    ST_EVAL     = 4'b0010,
    ST_POP_RTT  = 4'b0100,
    ST_POP_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // captured event word
  op_e                op_q;
  logic [TIME_W-1:0]  now_q;
  logic               is_ack_q;
  logic signed [31:0] ack_q;
  logic [SEQ_W-1:0]   rx_q;

  // window state
  logic [SEQ_W-1:0]  head_seq_q, head_seq_d, next_seq_q, next_seq_d;
  logic [SEQ_W-1:0]  exp_q, exp_d;
  logic [CntW-1:0]   outstanding_q, outstanding_d;
  logic [WlW-1:0]    wl_q, wl_d;
  logic              avoid_q, avoid_d;
  logic [TIME_W-1:0] lit_q, lit_d;
  logic [6:0]        npop_q, npop_d;
  logic [TO_W-1:0]   max_to_q;

  // output word register
  logic               out_valid_q, out_valid_d;
  kind_e              o_kind_q, e_kind;
  logic [SEQ_W-1:0]   o_seq_q, e_seq, o_as_q, e_as, o_bs_q, e_bs;
  logic               o_av_q, e_av, o_bv_q, e_bv, o_last_q, e_last;
  logic [6:0]         o_cnt_q, e_cnt;
  logic [31:0]        o_ack_q, e_ack;
  logic [15:0]        o_rtt_q;
  logic               emit, out_free;

  // cell chain
  cell_ctl_t         cell_ctl;
  logic [TIME_W-1:0] cell_time [WINDOW_DEPTH];
  logic              cell_retx [WINDOW_DEPTH];

  rtt_ctl_t          rtt_ctl;
  logic [RTT_W-1:0]  rtt;
  logic [TO_W-1:0]   timeout;

  // helpers
  logic [TIME_W-1:0] elapsed, lit_elapsed;
  logic              head_older, lit_older, has_out, send_full, loss_go;
  logic              ack_ge_head, ack_ge_next, dup_ack, more;
  logic [WlW-1:0]    out_ext, out_n_ext, wl_half, wl_new, loss_cnt, wl_g;
  logic [SEQ_W-1:0]  hs_n, exp_n;
  logic [CntW-1:0]   out_n;

  genvar g;
  generate
    for (g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
      if (g == WINDOW_DEPTH - 1) begin : g_end
        rws_cell u_cell (
          .clk_i     (clk_i),
          .ctl_i     (cell_ctl),
          .idx_i     (POS_W'(g)),
          .nb_time_i (cell_time[g]),
          .nb_retx_i (cell_retx[g]),
          .time_o    (cell_time[g]),
          .retx_o    (cell_retx[g])
        );
      end else begin : g_mid
        rws_cell u_cell (
          .clk_i     (clk_i),
          .ctl_i     (cell_ctl),
          .idx_i     (POS_W'(g)),
          .nb_time_i (cell_time[g+1]),
          .nb_retx_i (cell_retx[g+1]),
          .time_o    (cell_time[g]),
          .retx_o    (cell_retx[g])
        );
      end
    end
  endgenerate

  rws_rtt u_rtt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (rtt_ctl),
    .rtt_o     (rtt),
    .timeout_o (timeout)
  );

  // ages against the smoothed rtt
  assign elapsed     = now_q - cell_time[0];
  assign lit_elapsed = now_q - lit_q;
  assign head_older  = elapsed > {16'h0000, rtt[23:8]};
  assign lit_older   = lit_elapsed > {16'h0000, rtt[23:8]};

  assign out_ext     = WlW'(outstanding_q);
  assign has_out     = outstanding_q != '0;
  assign send_full   = (out_ext >= wl_q) || (outstanding_q >= CntW'(WINDOW_DEPTH));
  assign dup_ack     = ack_q == ($signed({1'b0, head_seq_q}) - 32'sd1);
  assign ack_ge_head = ack_q >= $signed({1'b0, head_seq_q});

  assign hs_n        = head_seq_q + 1'b1;
  assign out_n       = outstanding_q - 1'b1;
  assign out_n_ext   = WlW'(out_n);
  assign ack_ge_next = ack_q >= $signed({1'b0, hs_n});
  assign wl_g        = wl_q + 1'b1;
  assign wl_half     = wl_q >> 1;
  assign wl_new      = (wl_half == '0) ? WlW'(1) : wl_half;
  assign loss_cnt    = (out_ext < wl_new) ? out_ext : wl_new;
  assign exp_n       = (rx_q == exp_q) ? (exp_q + 1'b1) : exp_q;

  assign out_free    = !out_valid_q || !out_stall_i;

  // event sequencer
  always_comb begin
    state_d       = state_q;
    head_seq_d    = head_seq_q;
    next_seq_d    = next_seq_q;
    exp_d         = exp_q;
    outstanding_d = outstanding_q;
    wl_d          = wl_q;
    avoid_d       = avoid_q;
    lit_d         = lit_q;
    npop_d        = npop_q;
    cell_ctl      = '0;
    cell_ctl.now  = now_q;
    rtt_ctl       = '0;
    rtt_ctl.elapsed = elapsed;
    rtt_ctl.to_cap  = max_to_q;
    emit    = 1'b0;
    loss_go = 1'b0;
    more    = 1'b0;
    e_kind  = KIND_NONE;
    e_seq   = '0;
    e_av    = 1'b0;
    e_as    = '0;
    e_bv    = 1'b0;
    e_bs    = '0;
    e_cnt   = '0;
    e_ack   = '0;
    e_last  = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (out_free) begin
          state_d = ST_IDLE;
          emit    = 1'b1;
          e_last  = 1'b1;
          unique case (op_q)
            OP_SEND: begin
              e_seq = next_seq_q;
              if (send_full) begin
                e_kind = KIND_REFUSED;
              end else begin
                e_kind            = KIND_TX_NEW;
                cell_ctl.send_en  = 1'b1;
                cell_ctl.send_pos = POS_W'(outstanding_q);
                outstanding_d     = outstanding_q + 1'b1;
                next_seq_d        = next_seq_q + 1'b1;
              end
            end
            OP_TIMER: begin
              loss_go = has_out && (elapsed >= {16'h0000, timeout});
            end
            OP_RECV: begin
              if (has_out && dup_ack && head_older) begin
                loss_go = 1'b1;
              end else if (has_out && ack_ge_head) begin
                emit    = 1'b0;
                state_d = ST_POP_RTT;
                npop_d  = '0;
              end else if (!is_ack_q) begin
                exp_d  = exp_n;
                e_kind = KIND_SEND_ACK;
                e_ack  = {1'b0, exp_n} - 32'd1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_POP_RTT: begin
        rtt_ctl.sample_en = !cell_retx[0];
        state_d           = ST_POP_EMIT;
      end
      ST_POP_EMIT: begin
        if (out_free) begin
          emit          = 1'b1;
          e_kind        = KIND_ACKED;
          e_seq         = head_seq_q;
          cell_ctl.pop  = 1'b1;
          head_seq_d    = hs_n;
          outstanding_d = out_n;
          // tail resend at the current limit
          if (out_n_ext >= wl_q) begin
            e_av                = 1'b1;
            e_as                = hs_n + SEQ_W'(wl_q) - 1'b1;
            cell_ctl.tail_a_en  = 1'b1;
            cell_ctl.tail_a_pos = POS_W'(wl_q - 1'b1);
          end
          // window growth, then tail resend at the grown limit
          if (!avoid_q || lit_older) begin
            if (avoid_q) lit_d = now_q;
            wl_d = (wl_g > WlW'(WINDOW_DEPTH)) ? WlW'(WINDOW_DEPTH) : wl_g;
            if ((out_n_ext >= wl_g) && (wl_g <= WlW'(WINDOW_DEPTH))) begin
              e_bv                = 1'b1;
              e_bs                = hs_n + SEQ_W'(wl_q);
              cell_ctl.tail_b_en  = 1'b1;
              cell_ctl.tail_b_pos = POS_W'(wl_q);
            end
          end
          npop_d  = npop_q + 1'b1;
          more    = (out_n != '0) && (npop_d < 7'(MAX_POPS)) && ack_ge_next;
          e_last  = !more;
          state_d = more ? ST_POP_RTT : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // loss: halve window, resend from the head
    if (loss_go) begin
      e_kind           = KIND_LOSS;
      e_seq            = head_seq_q;
      e_cnt            = 7'(loss_cnt);
      wl_d             = wl_new;
      avoid_d          = 1'b1;
      lit_d            = now_q;
      rtt_ctl.loss_en  = 1'b1;
      cell_ctl.loss_en = 1'b1;
      cell_ctl.loss_cnt = POS_W'(loss_cnt);
    end

    // output word register
    out_valid_d = out_valid_q && out_stall_i;
    if (emit) out_valid_d = 1'b1;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      head_seq_q    <= '0;
      next_seq_q    <= '0;
      exp_q         <= '0;
      outstanding_q <= '0;
      wl_q          <= WlW'(1);
      avoid_q       <= 1'b0;
      lit_q         <= '0;
      npop_q        <= '0;
      max_to_q      <= MAX_TIMEOUT_RESET;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      head_seq_q    <= head_seq_d;
      next_seq_q    <= next_seq_d;
      exp_q         <= exp_d;
      outstanding_q <= outstanding_d;
      wl_q          <= wl_d;
      avoid_q       <= avoid_d;
      lit_q         <= lit_d;
      npop_q        <= npop_d;
      out_valid_q   <= out_valid_d;
      if (psel && penable && pwrite && (paddr[2] == REG_MAX_TIMEOUT)) begin
        max_to_q <= pwdata[15:0];
      end
    end
  end

  // event capture and result payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && (state_q == ST_IDLE)) begin
      op_q     <= op_e'(operation_i);
      now_q    <= now_ms_i;
      is_ack_q <= is_ack_i;
      ack_q    <= ack_number_i;
      rx_q     <= rx_sequence_i;
    end
    if (emit) begin
      o_kind_q <= e_kind;
      o_seq_q  <= e_seq;
      o_av_q   <= e_av;
      o_as_q   <= e_as;
      o_bv_q   <= e_bv;
      o_bs_q   <= e_bs;
      o_cnt_q  <= e_cnt;
      o_ack_q  <= e_ack;
      o_rtt_q  <= rtt[23:8];
      o_last_q <= e_last;
    end
  end

  assign in_stall_o         = state_q != ST_IDLE;
  assign out_valid_o        = out_valid_q;
  assign kind_o             = o_kind_q;
  assign sequence_res_o     = o_seq_q;
  assign resend_a_valid_o   = o_av_q;
  assign resend_a_seq_o     = o_as_q;
  assign resend_b_valid_o   = o_bv_q;
  assign resend_b_seq_o     = o_bs_q;
  assign retransmit_count_o = o_cnt_q;
  assign ack_out_o          = o_ack_q;
  assign rtt_ms_o           = o_rtt_q;
  assign last_o             = o_last_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_TIMEOUT) ? {16'h0000, max_to_q} : 32'h0;

  // checks
  `RWS_ASSERT_ALWAYS(a_seq_span, SEQ_W'(next_seq_q - head_seq_q) == SEQ_W'(outstanding_q))
  `RWS_ASSERT_ALWAYS(a_wl_range, (wl_q != '0) && (wl_q <= WlW'(WINDOW_DEPTH)))
  `RWS_ASSERT_NEXT(a_pop_dec, (state_q == ST_POP_EMIT) && out_free, outstanding_q == CntW'($past(outstanding_q) - 1'b1))

endmodule

[test/rws_checker.sv]
`timescale 1ns / 100ps
// result checker for reliable_window_sender_unit: tracks register writes,
// predicts the result words of every accepted event and compares them
// depends on rws_pkg
module rws_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic [31:0]        now_ms_i,
  input  logic               is_ack_i,
  input  logic [31:0]        ack_number_i,
  input  logic [30:0]        rx_sequence_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic [2:0]         kind_o,
  input  logic [30:0]        sequence_res_o,
  input  logic               resend_a_valid_o,
  input  logic [30:0]        resend_a_seq_o,
  input  logic               resend_b_valid_o,
  input  logic [30:0]        resend_b_seq_o,
  input  logic [6:0]         retransmit_count_o,
  input  logic [31:0]        ack_out_o,
  input  logic [15:0]        rtt_ms_o,
  input  logic               last_o,
  output int                 err_count_o,
  output int                 pending_o,
  output int                 words_seen_o
);
  import rws_pkg::*;

  localparam int unsigned DEPTH = 64;

  typedef struct packed {
    logic [2:0]  kind;
    logic [30:0] seq;
    logic        a_vld;
    logic [30:0] a_seq;
    logic        b_vld;
    logic [30:0] b_seq;
    logic [6:0]  cnt;
    logic [31:0] ack;
    logic [15:0] rtt;
    logic        last;
  } word_t;

  word_t expected_words[$];

  // sender state mirror
  logic [31:0] stamp [DEPTH];
  logic        resent [DEPTH];
  int          head_idx, in_flight, win_limit, ss_thresh;
  logic [30:0] head_seq, next_seq, rx_expect;
  logic        avoid;
  logic [31:0] last_grow;
  logic [23:0] srtt, rttvar;
  logic [15:0] rto, rto_cap;

  assign pending_o = expected_words.size();

  function automatic bit older_than_srtt(logic [31:0] el);
    return {8'd0, el, 8'd0} > {24'd0, srtt};
  endfunction

  task automatic post(logic [2:0] k, logic [30:0] sq, logic av, logic [30:0] as,
                      logic bv, logic [30:0] bs, logic [6:0] cnt, logic [31:0] ack);
    word_t w;
    w = '{k, sq, av, as, bv, bs, cnt, ack, srtt[23:8], 1'b0};
    expected_words.push_back(w);
  endtask

  // smoothed rtt and deviation in Q16.8, then the timeout derived from them
  task automatic rtt_sample(logic [31:0] el);
    longint unsigned smp, big, diff, d, r, t;
    smp = (el > 32'd65535) ? 65535 : el;
    big = smp << 8;
    diff = (big > srtt) ? big - srtt : srtt - big;
    d = (179 * longint'(rttvar) + 77 * diff + 128) >> 8;
    r = (3 * longint'(srtt) + big + 2) >> 2;
    rttvar = (d > 24'hFFFFFF) ? 24'hFFFFFF : d[23:0];
    srtt = (r > 24'hFFFFFF) ? 24'hFFFFFF : r[23:0];
    t = (2 * longint'(srtt) + 4 * longint'(rttvar)) >> 8;
    rto = (t > 65535) ? 16'hFFFF : t[15:0];
  endtask

  task automatic tail_resend(logic [31:0] now, output logic vld, output logic [30:0] sq);
    int s;
    vld = 1'b0;
    sq = '0;
    if (win_limit < 1 || in_flight < win_limit || win_limit > DEPTH) return;
    s = (head_idx + win_limit - 1) % DEPTH;
    resent[s] = 1'b1;
    stamp[s] = now;
    sq = head_seq + 31'(win_limit - 1);
    vld = 1'b1;
  endtask

  task automatic loss_event(logic [31:0] now);
    logic [31:0] t;
    int cnt;
    t = {16'd0, rto} * 2;
    if (t > {16'd0, rto_cap}) t = {16'd0, rto_cap};
    rto = t[15:0];
    win_limit = win_limit / 2;
    if (win_limit < 1) win_limit = 1;
    ss_thresh = win_limit;
    avoid = 1'b1;
    last_grow = now;
    cnt = 0;
    for (int i = 0; i < in_flight && i < win_limit; i++) begin
      resent[(head_idx + i) % DEPTH] = 1'b1;
      stamp[(head_idx + i) % DEPTH] = now;
      cnt++;
    end
    post(KIND_LOSS, head_seq, 0, 0, 0, 0, 7'(cnt), 0);
  endtask

  task automatic predict_event(logic [1:0] op, logic [31:0] now, logic ack_flag,
                               logic [31:0] ackn, logic [30:0] rx);
    longint ack_s;
    int n, s;
    logic av, bv;
    logic [30:0] as, bs, popped;
    ack_s = longint'($signed(ackn));
    n = 0;
    if (op == OP_SEND) begin
      if (in_flight >= win_limit || in_flight >= DEPTH) begin
        post(KIND_REFUSED, next_seq, 0, 0, 0, 0, 0, 0);
      end else begin
        s = (head_idx + in_flight) % DEPTH;
        stamp[s] = now;
        resent[s] = 1'b0;
        in_flight++;
        post(KIND_TX_NEW, next_seq, 0, 0, 0, 0, 0, 0);
        next_seq = next_seq + 1;
      end
    end else if (op == OP_TIMER) begin
      if (in_flight > 0 && (now - stamp[head_idx]) >= {16'd0, rto}) loss_event(now);
      else post(KIND_NONE, 0, 0, 0, 0, 0, 0, 0);
    end else if (op == OP_RECV) begin
      if (in_flight > 0 && ack_s == longint'(head_seq) - 1 &&
          older_than_srtt(now - stamp[head_idx])) begin
        loss_event(now);
      end else begin
        while (in_flight > 0 && n < MAX_POPS && ack_s >= longint'(head_seq)) begin
          popped = head_seq;
          if (!resent[head_idx]) rtt_sample(now - stamp[head_idx]);
          head_idx = (head_idx + 1) % DEPTH;
          head_seq = head_seq + 1;
          in_flight--;
          tail_resend(now, av, as);
          bv = 1'b0;
          bs = '0;
          if (!avoid) begin
            win_limit++;
            tail_resend(now, bv, bs);
          end else if (older_than_srtt(now - last_grow)) begin
            last_grow = now;
            win_limit++;
            tail_resend(now, bv, bs);
          end
          if (win_limit > DEPTH) win_limit = DEPTH;
          post(KIND_ACKED, popped, av, as, bv, bs, 0, 0);
          n++;
        end
        if (n == 0) begin
          if (!ack_flag) begin
            if (rx == rx_expect) rx_expect = rx_expect + 1;
            post(KIND_SEND_ACK, 0, 0, 0, 0, 0, 0, {1'b0, rx_expect} - 32'd1);
          end else begin
            post(KIND_NONE, 0, 0, 0, 0, 0, 0, 0);
          end
        end
      end
    end else begin
      post(KIND_NONE, 0, 0, 0, 0, 0, 0, 0);
    end
    expected_words[expected_words.size() - 1].last = 1'b1;
  endtask

  // compare one accepted word against the oldest expectation
  task automatic check_word();
    word_t got, exp_w;
    got = '{kind_o, sequence_res_o, resend_a_valid_o, resend_a_seq_o, resend_b_valid_o,
            resend_b_seq_o, retransmit_count_o, ack_out_o, rtt_ms_o, last_o};
    words_seen_o++;
    if (expected_words.size() == 0) begin
      err_count_o++;
      if (err_count_o <= 10) $display("ERROR: unexpected word %p", got);
      return;
    end
    exp_w = expected_words.pop_front();
    if (got !== exp_w) begin
      err_count_o++;
      if (err_count_o <= 10)
        $display("ERROR: word %0d mismatch\n  expected %p\n  actual   %p",
                 words_seen_o, exp_w, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_words.delete();
      head_idx = 0; in_flight = 0; win_limit = 1; ss_thresh = 1;
      head_seq = '0; next_seq = '0; rx_expect = '0; avoid = 1'b0;
      last_grow = '0; srtt = RTT_RESET; rttvar = DEV_RESET;
      rto = TIMEOUT_RESET; rto_cap = MAX_TIMEOUT_RESET;
      for (int i = 0; i < DEPTH; i++) begin
        stamp[i] = '0;
        resent[i] = 1'b0;
      end
      err_count_o = 0;
      words_seen_o = 0;
    end else begin
      if (out_valid_o && !out_stall_i) check_word();
      if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_TIMEOUT)
        rto_cap = pwdata[15:0];
      if (in_valid_i && !in_stall_o)
        predict_event(operation_i, now_ms_i, is_ack_i, ack_number_i, rx_sequence_i);
    end
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// top of the reliable window sender testbench: clock, reset, event and
// register stimulus, result-side stalls and the verdict; uses rws_checker
module tb_top;
  import rws_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid_i, in_stall_o, is_ack_i;
  logic [1:0] operation_i;
  logic [31:0] now_ms_i;
  logic signed [31:0] ack_number_i;
  logic [30:0] rx_sequence_i;
  logic out_valid_o, out_stall_i, resend_a_valid_o, resend_b_valid_o, last_o;
  logic [2:0] kind_o;
  logic [30:0] sequence_res_o, resend_a_seq_o, resend_b_seq_o;
  logic [6:0] retransmit_count_o;
  logic signed [31:0] ack_out_o;
  logic [15:0] rtt_ms_o;

  int err_count, pending, words_seen;
  int events_sent;
  bit calm, hold_req, hold_done;
  int idle_run;
  logic [31:0] clock_ms;
  int sends_issued;
  logic signed [31:0] last_ack;
  logic [30:0] peer_seq;

  reliable_window_sender_unit dut (.*);

  rws_checker checker_i (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .in_valid_i, .in_stall_o, .operation_i, .now_ms_i, .is_ack_i,
    .ack_number_i, .rx_sequence_i, .out_valid_o, .out_stall_i, .kind_o,
    .sequence_res_o, .resend_a_valid_o, .resend_a_seq_o, .resend_b_valid_o,
    .resend_b_seq_o, .retransmit_count_o, .ack_out_o, .rtt_ms_o, .last_o,
    .err_count_o(err_count), .pending_o(pending), .words_seen_o(words_seen)
  );

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_stall_i <= !calm && ($urandom_range(0, 99) < 38);
    end
  end

  // watchdog on cycles with no word moving
  initial begin
    idle_run = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_run = 0;
      else idle_run++;
      if (idle_run >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d idle cycles, %0d words pending", idle_run, pending);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // drain results and let an ack pop chain finish before touching registers
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic send_event(op_e op, logic [31:0] now, logic ack_flag,
                            logic [31:0] ackn, logic [30:0] rx);
    int gap;
    if (!calm && $urandom_range(0, 99) < 38) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op; now_ms_i <= now; is_ack_i <= ack_flag;
    ack_number_i <= ackn; rx_sequence_i <= rx;
    do @(posedge clk_i); while (in_stall_o);
    events_sent++;
    if (op == OP_SEND) sends_issued++;
  endtask

  // one random event, mostly a plausible link exchange
  task automatic random_event();
    int pick;
    logic [31:0] ackn;
    logic [30:0] rx;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 3) clock_ms = $urandom;
    else clock_ms += $urandom_range(0, 400);
    if (pick < 45) begin
      send_event(OP_SEND, clock_ms, 1'($urandom), $urandom, 31'($urandom));
    end else if (pick < 80) begin
      if ($urandom_range(0, 99) < 85) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) ackn = $urandom;
        else if (pick < 20) ackn = last_ack;
        else begin
          ackn = last_ack + $urandom_range(0, 4);
          if ($signed(ackn) > sends_issued - 1) ackn = sends_issued - 1;
        end
        last_ack = ackn;
        send_event(OP_RECV, clock_ms, 1'b1, ackn, 31'($urandom));
      end else begin
        rx = ($urandom_range(0, 9) == 0) ? 31'($urandom) : peer_seq;
        if (rx == peer_seq) peer_seq++;
        send_event(OP_RECV, clock_ms, 1'b0, $urandom, rx);
      end
    end else if (pick < 95) begin
      clock_ms += $urandom_range(0, 2500);
      send_event(OP_TIMER, clock_ms, 1'($urandom), $urandom, 31'($urandom));
    end else begin
      send_event(OP_RSVD, clock_ms, 1'($urandom), $urandom, 31'($urandom));
    end
  endtask

  initial begin
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid_i = 0; operation_i = OP_SEND; now_ms_i = '0; is_ack_i = 0;
    ack_number_i = '0; rx_sequence_i = '0;
    calm = 0; hold_req = 0; events_sent = 0; sends_issued = 0;
    last_ack = -1; peer_seq = '0;
    clock_ms = 32'hFFFF_FE00;
    @(posedge rst_ni);
    @(posedge clk_i);

    // directed: empty window, go-back-n acks, reserved op, refusal, pops,
    // duplicate ack, timeout, huge and negative acks, time wrap
    send_event(OP_TIMER, clock_ms, 0, 0, 0);
    send_event(OP_RECV, clock_ms, 1, 32'hFFFF_FFFF, 0);
    send_event(OP_RECV, clock_ms, 0, 0, 31'd0);
    send_event(OP_RECV, clock_ms, 0, 0, 31'd5);
    send_event(OP_RECV, clock_ms, 0, 0, 31'h7FFF_FFFF);
    send_event(OP_RSVD, 32'hFFFF_FFFF, 1, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_event(OP_SEND, clock_ms, 0, 0, 0);
    send_event(OP_SEND, clock_ms + 1, 0, 0, 0);
    send_event(OP_RECV, clock_ms + 50, 1, 0, 0);
    for (int i = 0; i < 3; i++) send_event(OP_SEND, clock_ms + 60 + i, 0, 0, 0);
    send_event(OP_TIMER, clock_ms + 100, 0, 0, 0);
    send_event(OP_RECV, clock_ms + 600, 1, 0, 0);
    send_event(OP_TIMER, clock_ms + 5000, 0, 0, 0);
    send_event(OP_RECV, clock_ms + 5100, 1, 32'h7FFF_FFFF, 0);
    send_event(OP_RECV, clock_ms + 5200, 1, 32'h8000_0000, 0);
    for (int i = 0; i < 3; i++) send_event(OP_SEND, clock_ms + 5300, 0, 0, 0);
    send_event(OP_RECV, 32'h0000_0000, 1, 32'd6, 0);
    clock_ms = 32'd200;
    last_ack = 6;

    // random phases across register settings, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: reg_write(3'd0, 32'd65535);
        1: reg_write(3'd0, 32'd1);
        2: reg_write(3'd0, $urandom_range(2, 65534));
        3: reg_write(3'd0, 32'hFFFF_0000 | 32'd2000);
        default: reg_write(3'd0, 32'd0);
      endcase
      for (int i = 0; i < 42; i++) begin
        calm = (ph == 2 && i >= 10 && i < 40);
        if (ph == 1 && i == 20) hold_req = 1'b1;
        random_event();
      end
      calm = 0;
    end

    settle();
    $display("covered %0d events and %0d result words over five timeout caps,",
             events_sent, words_seen);
    $display("with sender gaps, result stalls and one long result hold-off");
    if (err_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/rws_pkg.sv
sv/rws_cell.sv
sv/rws_rtt.sv
sv/reliable_window_sender_unit.sv
test/rws_checker.sv
test/tb_top.sv
